// ----- design/fir_pkg.sv -----
package fir_pkg;

    localparam int TAPS     = 16;
    localparam int W_SAMPLE = 16;
    localparam int W_INDEX  = 4;
    localparam int W_PROD   = 2 * W_SAMPLE;
    localparam int W_ACC    = 36;
    localparam int W_FILL   = $clog2(TAPS + 1);

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_PUSH = 1'b1;

    typedef logic signed [W_SAMPLE-1:0] t_sample;
    typedef logic signed [W_ACC-1:0]    t_acc;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    typedef struct packed {
        logic tok;
        t_acc acc;
    } t_sum;

endpackage

// ----- design/fir_if.sv -----
interface fir_in_if
    import fir_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [W_INDEX-1:0]    tap_index;
    t_sample               tap_value;
    t_sample               sample;

    modport source (output valid, mode, tap_index, tap_value, sample, input ready);
    modport sink   (input valid, mode, tap_index, tap_value, sample, output ready);
endinterface

interface fir_out_if
    import fir_pkg::*;
();
    logic valid;
    logic ready;
    t_acc filtered;

    modport source (output valid, filtered, input ready);
    modport sink   (input valid, filtered, output ready);
endinterface

// ----- design/fir_cell.sv -----
module fir_cell
    import fir_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_sample   i_sample,
    input  t_sample   i_tap_value,
    input  t_sum      i_sum,
    output t_sample   o_sample,
    output t_sum      o_sum
);

    t_sample                   r_win;
    t_sample                   r_tap;
    logic signed [W_PROD-1:0]  r_prod;
    t_sum                      r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
            r_tap <= '0;
        end else begin
            if (i_ctl.shift) begin
                r_win <= i_sample;
            end
            if (i_ctl.load) begin
                r_tap <= i_tap_value;
            end
        end
    end

    // product of the stored pair is registered
    always_ff @(posedge i_clk) begin
        r_prod <= W_PROD'(r_win) * W_PROD'(r_tap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum.tok <= 1'b0;
        end else begin
            r_sum.tok <= i_sum.tok;
        end
        if (i_sum.tok) begin
            r_sum.acc <= i_sum.acc + t_acc'(r_prod);
        end
    end

    assign o_sample = r_win;
    assign o_sum    = r_sum;

endmodule

// ----- design/fir_filter.sv -----
// fir filter over signed 16-bit samples, direct form, no tap reversal
// input channel i_in: mode 0 writes tap_value into tap tap_index (indexes
// at or above TAPS are dropped), mode 1 pushes sample into the window
// output channel o_out: filtered is the exact 36-bit sum of products, 2^-15
// a push yields a transaction once TAPS samples have arrived since reset
// loads and pushes without a result leave the input side open
// a push with a result runs a partial sum down the chain of TAPS cells,
// one cell a cycle, started through r_go and r_go_d; filtered is registered
// from the end of the chain
// i_in.ready stays low from that push until its result is taken, so a
// stalled receiver holds both the result and the input side
// reset clears window, taps and fill count, no pass is pending
module fir_filter
    import fir_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    fir_in_if.sink     i_in,
    fir_out_if.source  o_out
);

    logic [W_FILL-1:0] r_fill;
    logic [W_FILL-1:0] n_fill;
    logic              r_busy;
    logic              r_go;
    logic              r_go_d;
    logic              r_out_valid;
    t_acc              r_out_data;

    logic              in_acc;
    logic              push;
    logic              fires;

    t_sample           win   [TAPS+1];
    t_sum              sums  [TAPS+1];
    logic [TAPS-1:0]   toks;

    assign i_in.ready = !r_busy;
    assign in_acc     = i_in.valid && i_in.ready;
    assign push       = in_acc && (i_in.mode == MODE_PUSH);
    assign n_fill     = (r_fill < W_FILL'(TAPS)) ? r_fill + 1'b1 : r_fill;
    assign fires      = push && (n_fill == W_FILL'(TAPS));

    assign win[TAPS]   = i_in.sample;
    assign sums[0].tok = r_go_d;
    assign sums[0].acc = '0;

    genvar g;
    generate
        for (g = 0; g < TAPS; g++) begin : g_cell
            t_cell_ctl ctl;
            assign ctl.shift = push;
            assign ctl.load  = in_acc && (i_in.mode == MODE_LOAD)
                               && (32'(i_in.tap_index) == g);
            assign toks[g]   = sums[g+1].tok;

            fir_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (ctl),
                .i_sample    (win[g+1]),
                .i_tap_value (i_in.tap_value),
                .i_sum       (sums[g]),
                .o_sample    (win[g]),
                .o_sum       (sums[g+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_busy      <= 1'b0;
            r_go        <= 1'b0;
            r_go_d      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_go   <= fires;
            r_go_d <= r_go;
            if (push) begin
                r_fill <= n_fill;
            end
            if (fires) begin
                r_busy <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_busy <= 1'b0;
            end
            if (sums[TAPS].tok) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (sums[TAPS].tok) begin
            r_out_data <= sums[TAPS].acc;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.filtered = r_out_data;

`ifndef ASSERT_OFF
    // at most one partial sum travels the chain
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(toks))
        else $error("more than one partial sum in the chain");

    // a held result keeps the input side closed
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_busy)
        else $error("result pending while block is open");

    // a pass in flight only while busy
    a_tok_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_go || r_go_d || (toks != '0)) |-> r_busy)
        else $error("pass running while block is open");

    // no new pass starts before the previous result leaves
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fires |-> !r_out_valid && !r_go && !r_go_d && (toks == '0))
        else $error("pass started over a pending one");

    // a finished pass lands in the output register
    a_land: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sums[TAPS].tok |=> r_out_valid)
        else $error("result lost at the chain end");
`endif

endmodule
